// ----- rtl/windowed_average_max_min_defines.svh -----
// ----------------------------------------------------------------------------
// Windowed average / max / min - assertion macros
// Shared macros for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_AVERAGE_MAX_MIN_DEFINES_SVH
`define WINDOWED_AVERAGE_MAX_MIN_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define WAMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define WAMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wamm_pkg.sv -----
// ----------------------------------------------------------------------------
// wamm_pkg
// Types, sizes and helpers shared by the windowed average / max / min block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wamm_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + ADDR_W;
    localparam int NUM_AXES   = 3;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int LEN_RESET  = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [ADDR_W-1:0]          addr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIVIDE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic sample_load;
        logic update;
        logic scan_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic scan_last;
        logic div_done;
    } status_t;

    // Clamp a written window length into 1..WINDOW_MAX
    function automatic len_t eff_len(input len_t value);
        len_t res;
        res = value;
        if (value == '0)
        begin
            res = len_t'(1);
        end
        else if (value > len_t'(WINDOW_MAX))
        begin
            res = len_t'(WINDOW_MAX);
        end
        return res;
    endfunction

endpackage

// ----- rtl/windowed_average_max_min.sv -----
// ----------------------------------------------------------------------------
// windowed_average_max_min
// Sliding-window average, maximum and minimum of three-axis gyro samples.
// ----------------------------------------------------------------------------
// Each accepted input beat is written into a per-axis ring buffer of the last
// L samples (L = window_length, 0 taken as 1, above 1024 taken as 1024). Until
// L samples have arrived a beat gives no result. Once the window is full each
// beat gives one result: the running sums are updated, the window is walked
// entry by entry through the read port of each axis RAM for max/min, the last
// compare is made and the result is loaded. A 26-step serial divider runs
// alongside the walk to form the truncated average and sets the floor for
// short windows. The next beat can be taken in the cycle after the result
// loads. The input stalls while a beat is in work; a finished result sits in
// an output register, so a new beat is taken while the previous result still
// waits, and the next result waits for it to leave. Any write of window_length
// restarts the window; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_average_max_min (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [10:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [15:0]   sample_x,
    input  logic signed [15:0]   sample_y,
    input  logic signed [15:0]   sample_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   echo_x,
    output logic signed [15:0]   echo_y,
    output logic signed [15:0]   echo_z,
    output logic signed [15:0]   avg_x,
    output logic signed [15:0]   avg_y,
    output logic signed [15:0]   avg_z,
    output logic signed [15:0]   max_x,
    output logic signed [15:0]   max_y,
    output logic signed [15:0]   max_z,
    output logic signed [15:0]   min_x,
    output logic signed [15:0]   min_y,
    output logic signed [15:0]   min_z
);

    wamm_pkg::cmd_t    cmd;
    wamm_pkg::status_t status;
    wamm_pkg::sample_t in_sample [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t echo_out  [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t avg_out   [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t max_out   [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t min_out   [wamm_pkg::NUM_AXES];

    // Gather the axes into lanes
    assign in_sample[0] = sample_x;
    assign in_sample[1] = sample_y;
    assign in_sample[2] = sample_z;

    wamm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wamm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_sample (in_sample),
        .cmd       (cmd),
        .status    (status),
        .echo_out  (echo_out),
        .avg_out   (avg_out),
        .max_out   (max_out),
        .min_out   (min_out)
    );

    // Spread the lanes back onto the result ports
    assign echo_x = echo_out[0];
    assign echo_y = echo_out[1];
    assign echo_z = echo_out[2];
    assign avg_x  = avg_out[0];
    assign avg_y  = avg_out[1];
    assign avg_z  = avg_out[2];
    assign max_x  = max_out[0];
    assign max_y  = max_out[1];
    assign max_z  = max_out[2];
    assign min_x  = min_out[0];
    assign min_y  = min_out[1];
    assign min_z  = min_out[2];

endmodule

// ----- rtl/wamm_ram.sv -----
// ----------------------------------------------------------------------------
// wamm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wamm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/wamm_dp.sv -----
// ----------------------------------------------------------------------------
// wamm_dp
// Datapath: ring buffers, running sums, max/min scan, serial divider and
// result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wamm_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  wamm_pkg::len_t             cfg_wdata,
    input  wamm_pkg::sample_t          in_sample [wamm_pkg::NUM_AXES],
    input  wamm_pkg::cmd_t             cmd,
    output wamm_pkg::status_t          status,
    output wamm_pkg::sample_t          echo_out  [wamm_pkg::NUM_AXES],
    output wamm_pkg::sample_t          avg_out   [wamm_pkg::NUM_AXES],
    output wamm_pkg::sample_t          max_out   [wamm_pkg::NUM_AXES],
    output wamm_pkg::sample_t          min_out   [wamm_pkg::NUM_AXES]
);

    // Window control
    wamm_pkg::len_t    len_reg;
    wamm_pkg::addr_t   pos_reg, pos_next;
    wamm_pkg::len_t    fill_reg, fill_next;
    wamm_pkg::len_t    pos_inc;
    wamm_pkg::addr_t   scan_cnt_reg;
    wamm_pkg::addr_t   rd_addr;
    logic              full_before;
    logic              cmp_en_reg;
    logic              cmp_first_reg;

    // Per-axis data
    wamm_pkg::sample_t samp_reg  [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t rd_data   [wamm_pkg::NUM_AXES];
    wamm_pkg::sum_t    sum_reg   [wamm_pkg::NUM_AXES];
    wamm_pkg::sum_t    sum_next  [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t hi_reg    [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t lo_reg    [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t echo_reg  [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t avg_reg   [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t max_reg   [wamm_pkg::NUM_AXES];
    wamm_pkg::sample_t min_reg   [wamm_pkg::NUM_AXES];

    // Divider lanes
    logic [wamm_pkg::SUM_W-1:0]     quo_reg  [wamm_pkg::NUM_AXES];
    logic [wamm_pkg::SUM_W-1:0]     quo_next [wamm_pkg::NUM_AXES];
    wamm_pkg::len_t                 rem_reg  [wamm_pkg::NUM_AXES];
    wamm_pkg::len_t                 rem_next [wamm_pkg::NUM_AXES];
    logic [wamm_pkg::LEN_W:0]       trial    [wamm_pkg::NUM_AXES];
    logic [wamm_pkg::SUM_W-1:0]     quo_sgn  [wamm_pkg::NUM_AXES];
    logic                           neg_reg  [wamm_pkg::NUM_AXES];
    logic [wamm_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // Window bookkeeping for one update
    always_comb
    begin
        full_before = (fill_reg >= len_reg);
        fill_next   = full_before ? fill_reg : fill_reg + 1'b1;
        pos_inc     = {1'b0, pos_reg} + 1'b1;
        pos_next    = (pos_inc >= len_reg) ? '0 : pos_inc[wamm_pkg::ADDR_W-1:0];
        rd_addr     = cmd.scan_step ? scan_cnt_reg : pos_reg;
    end

    assign status.full      = (fill_next >= len_reg);
    assign status.scan_last = ({1'b0, scan_cnt_reg} == (len_reg - 1'b1));
    assign status.div_done  = (div_cnt_reg == '0);

    // Control registers: window position, fill, scan and divide counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= wamm_pkg::len_t'(wamm_pkg::LEN_RESET);
            pos_reg       <= '0;
            fill_reg      <= '0;
            scan_cnt_reg  <= '0;
            cmp_en_reg    <= 1'b0;
            cmp_first_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            cmp_en_reg    <= cmd.scan_step;
            cmp_first_reg <= cmd.scan_step && (scan_cnt_reg == '0);
            if (cfg_we)
            begin
                len_reg  <= wamm_pkg::eff_len(cfg_wdata);
                pos_reg  <= '0;
                fill_reg <= '0;
            end
            else if (cmd.update)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
            end
            if (cmd.update)
            begin
                scan_cnt_reg <= '0;
                div_cnt_reg  <= wamm_pkg::DIV_CNT_W'(wamm_pkg::DIV_STEPS);
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (div_cnt_reg != '0)
                begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
            end
        end
    end

    // Running sums, cleared on any window-length write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < wamm_pkg::NUM_AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            for (int a = 0; a < wamm_pkg::NUM_AXES; a++)
            begin
                if (cfg_we)
                begin
                    sum_reg[a] <= '0;
                end
                else if (cmd.update)
                begin
                    sum_reg[a] <= sum_next[a];
                end
            end
        end
    end

    // Per-axis lanes: ring buffer, sum update, divider step
    for (genvar g = 0; g < wamm_pkg::NUM_AXES; g++)
    begin : g_axis
        wamm_ram #(
            .WIDTH (wamm_pkg::SAMPLE_W),
            .DEPTH (wamm_pkg::WINDOW_MAX)
        ) u_store (
            .clk   (clk),
            .we    (cmd.update),
            .waddr (pos_reg),
            .wdata (samp_reg[g]),
            .raddr (rd_addr),
            .rdata (rd_data[g])
        );

        // Add the new sample, drop the one it replaces
        always_comb
        begin
            sum_next[g] = sum_reg[g] + wamm_pkg::SUM_W'(samp_reg[g]);
            if (full_before)
            begin
                sum_next[g] = sum_next[g] - wamm_pkg::SUM_W'(rd_data[g]);
            end
        end

        // One restoring-divide step per cycle while the divide counter is nonzero
        always_comb
        begin
            trial[g] = {rem_reg[g], quo_reg[g][wamm_pkg::SUM_W-1]};
            if (trial[g] >= {1'b0, len_reg})
            begin
                rem_next[g] = wamm_pkg::LEN_W'(trial[g] - {1'b0, len_reg});
                quo_next[g] = {quo_reg[g][wamm_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[g] = trial[g][wamm_pkg::LEN_W-1:0];
                quo_next[g] = {quo_reg[g][wamm_pkg::SUM_W-2:0], 1'b0};
            end
            quo_sgn[g] = neg_reg[g] ? (~quo_reg[g] + 1'b1) : quo_reg[g];
        end

        // Load the sample beat, run the divider, track max and min
        always_ff @(posedge clk)
        begin
            if (cmd.sample_load)
            begin
                samp_reg[g] <= in_sample[g];
            end
            if (cmd.update)
            begin
                neg_reg[g] <= sum_next[g][wamm_pkg::SUM_W-1];
                quo_reg[g] <= sum_next[g][wamm_pkg::SUM_W-1] ? -sum_next[g] : sum_next[g];
                rem_reg[g] <= '0;
            end
            else if (div_cnt_reg != '0)
            begin
                quo_reg[g] <= quo_next[g];
                rem_reg[g] <= rem_next[g];
            end
            if (cmp_en_reg)
            begin
                if (cmp_first_reg || (rd_data[g] > hi_reg[g]))
                begin
                    hi_reg[g] <= rd_data[g];
                end
                if (cmp_first_reg || (rd_data[g] < lo_reg[g]))
                begin
                    lo_reg[g] <= rd_data[g];
                end
            end
            if (cmd.out_load)
            begin
                echo_reg[g] <= samp_reg[g];
                avg_reg[g]  <= quo_sgn[g][wamm_pkg::SAMPLE_W-1:0];
                max_reg[g]  <= hi_reg[g];
                min_reg[g]  <= lo_reg[g];
            end
        end

        assign echo_out[g] = echo_reg[g];
        assign avg_out[g]  = avg_reg[g];
        assign max_out[g]  = max_reg[g];
        assign min_out[g]  = min_reg[g];
    end

endmodule

// ----- rtl/wamm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wamm_ctrl
// Controller: sequences the update for each input beat and, once the window
// is full, the window scan and divide; owns the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_average_max_min_defines.svh"

module wamm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  wamm_pkg::status_t  status,
    output wamm_pkg::cmd_t     cmd
);

    wamm_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wamm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            wamm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.sample_load = 1'b1;
                    state_next      = wamm_pkg::ST_UPDATE;
                end
            end
            wamm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.full ? wamm_pkg::ST_SCAN : wamm_pkg::ST_IDLE;
            end
            wamm_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = wamm_pkg::ST_SCAN_END;
                end
            end
            wamm_pkg::ST_SCAN_END:
            begin
                state_next = wamm_pkg::ST_DIVIDE;
            end
            wamm_pkg::ST_DIVIDE:
            begin
                if (status.div_done && !(out_valid_reg && out_stall))
                begin
                    cmd.out_load = 1'b1;
                    state_next   = wamm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wamm_pkg::ST_IDLE;
            end
        endcase
    end

    // Set on a new result, drop when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `WAMM_ASSERT_NOW(a_update_after_beat, state_reg == wamm_pkg::ST_UPDATE, $past(in_valid && !in_stall), "update without an accepted input beat")
    `WAMM_ASSERT_NOW(a_scan_end_on_last, state_reg == wamm_pkg::ST_SCAN_END, $past(status.scan_last), "scan ended before last window entry")
    `WAMM_ASSERT_NOW(a_result_from_divide, $rose(out_valid), $past(state_reg == wamm_pkg::ST_DIVIDE && status.div_done), "result raised outside a finished divide")
    `WAMM_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(out_valid_reg && out_stall), "result register overwritten while stalled")

endmodule

// ----- tb/sv/tb_windowed_average_max_min.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_average_max_min
// Self-checking testbench for the sliding-window average / max / min block.
// ----------------------------------------------------------------------------
// Gyro sample beats are driven through the valid/stall input channel. Each
// accepted beat goes into a scoreboard that keeps its own ring buffers,
// running sums and window length. The scoreboard queues the window it expects
// whenever the window is full. Every accepted output beat is compared field by
// field with the oldest queued window. Window lengths run over zero, one,
// small, odd, repeated and longer values and a saturating value whose window
// never fills, and every write restarts the window. Both channels idle at
// random, and one phase holds the output off long enough to back the block up
// into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_windowed_average_max_min;

    localparam int LIMIT        = 800000;
    localparam int DRAIN        = 1100;
    localparam int CFG_SETTLE   = 40;
    localparam int HOLD         = 3000;
    localparam int RANDOM_ITEMS = 160;

    // Field slots in one packed window result
    localparam int F_ECHO = 0;
    localparam int F_AVG  = 3;
    localparam int F_MAX  = 6;
    localparam int F_MIN  = 9;
    localparam int NUM_FIELDS = 12;

    typedef logic [NUM_FIELDS-1:0][wamm_pkg::SAMPLE_W-1:0] window_result_t;

    // Tracks the window contents and queues the result each beat should give
    class window_scoreboard;
        int              hist[wamm_pkg::NUM_AXES][wamm_pkg::WINDOW_MAX];
        longint          sums[wamm_pkg::NUM_AXES];
        int unsigned     wr_pos;
        int unsigned     fill;
        wamm_pkg::len_t  length_reg;
        window_result_t  expected_windows[$];
        string           labels[NUM_FIELDS];
        int              errors;
        int              beats;
        int              results;

        function new();
            labels = '{"echo_x", "echo_y", "echo_z", "avg_x", "avg_y", "avg_z",
                       "max_x", "max_y", "max_z", "min_x", "min_y", "min_z"};
            length_reg = wamm_pkg::len_t'(wamm_pkg::LEN_RESET);
            errors = 0;
            beats = 0;
            results = 0;
            restart();
        endfunction

        function void restart();
            wr_pos = 0;
            fill = 0;
            for (int a = 0; a < wamm_pkg::NUM_AXES; a++)
            begin
                sums[a] = 0;
            end
        endfunction

        // Any length write, same value included, starts a fresh window
        function void write_length(input wamm_pkg::len_t value);
            length_reg = value;
            restart();
        endfunction

        function int unsigned window_size();
            if (length_reg == 0)
            begin
                return 1;
            end
            if (length_reg > wamm_pkg::WINDOW_MAX)
            begin
                return wamm_pkg::WINDOW_MAX;
            end
            return length_reg;
        endfunction

        function void take_sample(input wamm_pkg::sample_t sx, input wamm_pkg::sample_t sy,
                                  input wamm_pkg::sample_t sz);
            int unsigned    len;
            int unsigned    pos;
            int             cur[wamm_pkg::NUM_AXES];
            int             hi;
            int             lo;
            window_result_t res;

            len = window_size();
            pos = wr_pos;
            if (pos >= len)
            begin
                pos = 0;
            end
            cur[0] = sx;
            cur[1] = sy;
            cur[2] = sz;
            beats++;

            // Drop the oldest sample once full, otherwise grow the window
            if (fill >= len)
            begin
                for (int a = 0; a < wamm_pkg::NUM_AXES; a++)
                begin
                    sums[a] -= hist[a][pos];
                end
            end
            else
            begin
                fill++;
            end

            for (int a = 0; a < wamm_pkg::NUM_AXES; a++)
            begin
                hist[a][pos] = cur[a];
                sums[a] += cur[a];
            end

            pos++;
            if (pos >= len)
            begin
                pos = 0;
            end
            wr_pos = pos;

            if (fill < len)
            begin
                return;
            end

            // Full window: echo, truncated average and a scan for max/min
            for (int a = 0; a < wamm_pkg::NUM_AXES; a++)
            begin
                hi = hist[a][0];
                lo = hist[a][0];
                for (int k = 1; k < len; k++)
                begin
                    if (hist[a][k] > hi)
                    begin
                        hi = hist[a][k];
                    end
                    if (hist[a][k] < lo)
                    begin
                        lo = hist[a][k];
                    end
                end
                res[F_ECHO + a] = 16'(cur[a]);
                res[F_AVG + a]  = 16'(sums[a] / longint'(len));
                res[F_MAX + a]  = 16'(hi);
                res[F_MIN + a]  = 16'(lo);
            end
            expected_windows.push_back(res);
        endfunction

        function void check_result(input window_result_t got);
            window_result_t want;

            if (expected_windows.size() == 0)
            begin
                errors++;
                $display("%0t: output beat with no window expected, actual echo_x %0d",
                         $time, $signed(got[F_ECHO]));
                return;
            end
            want = expected_windows.pop_front();
            results++;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (got[i] !== want[i])
                begin
                    errors++;
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                             labels[i], $signed(want[i]), $signed(got[i]));
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [10:0]       cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    wamm_pkg::sample_t sample_x;
    wamm_pkg::sample_t sample_y;
    wamm_pkg::sample_t sample_z;
    logic              out_valid;
    logic              out_stall;
    wamm_pkg::sample_t echo_x;
    wamm_pkg::sample_t echo_y;
    wamm_pkg::sample_t echo_z;
    wamm_pkg::sample_t avg_x;
    wamm_pkg::sample_t avg_y;
    wamm_pkg::sample_t avg_z;
    wamm_pkg::sample_t max_x;
    wamm_pkg::sample_t max_y;
    wamm_pkg::sample_t max_z;
    wamm_pkg::sample_t min_x;
    wamm_pkg::sample_t min_y;
    wamm_pkg::sample_t min_z;

    window_scoreboard sb = new();

    bit  calm;
    int  hold_cycles;
    int  cycle_count;
    int  phases;

    windowed_average_max_min dut (.*);

    always #1 clk = ~clk;

    // Abort on a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Output side: random stall before each beat, long hold when requested
    initial
    begin
        int             stall_for;
        window_result_t got;

        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_for = hold_cycles + (calm ? 0 : $urandom_range(0, 4));
            hold_cycles = 0;
            if (stall_for > 0)
            begin
                out_stall = 1'b1;
                repeat (stall_for) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            got = {min_z, min_y, min_x, max_z, max_y, max_x,
                   avg_z, avg_y, avg_x, echo_z, echo_y, echo_x};
            sb.check_result(got);
        end
    end

    function automatic wamm_pkg::sample_t rand_sample();
        case ($urandom_range(0, 7))
            0: return wamm_pkg::sample_t'(-32768);
            1: return wamm_pkg::sample_t'(32767);
            2: return wamm_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);
            default: return wamm_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_sample(input wamm_pkg::sample_t sx, input wamm_pkg::sample_t sy,
                               input wamm_pkg::sample_t sz);
        int gap;

        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        sample_x = sx;
        sample_y = sy;
        sample_z = sz;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.take_sample(sx, sy, sz);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic stop_stream();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait for every expected window, then let the block go quiet
    task automatic settle(input int cycles);
        while (sb.expected_windows.size() != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_window(input wamm_pkg::len_t value);
        settle(CFG_SETTLE);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        sb.write_length(value);
        phases++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int          count;
        int          random_done;
        int unsigned len_pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        sample_x = '0;
        sample_y = '0;
        sample_z = '0;
        calm = 1'b0;
        hold_cycles = 0;
        phases = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset length of 8: fill with extremes, then slide over them
        send_sample(32767, -32768, 0);
        send_sample(-32768, 32767, -1);
        send_sample(1, -1, 32767);
        send_sample(0, 0, -32768);
        send_sample(-1, 1, 1);
        send_sample(32767, 32767, -32768);
        send_sample(-32768, -32768, 32767);
        send_sample(2, -2, 0);
        send_sample(-32768, 32767, -32768);
        send_sample(32767, -32768, 32767);
        send_sample(0, 0, 0);
        send_sample(-1, -1, -1);
        stop_stream();

        // Zero length acts as a single-sample window
        write_window(0);
        send_sample(-32768, 32767, 0);
        send_sample(32767, -32768, -1);
        send_sample(0, -1, 1);
        stop_stream();

        // Two-sample window: negative odd sums truncate toward zero
        write_window(2);
        send_sample(-1, -1, 1);
        send_sample(0, 0, 0);
        send_sample(-3, 3, -32768);
        send_sample(0, 0, -32768);
        send_sample(-32768, 32767, 5);
        send_sample(-32768, 32767, -6);
        stop_stream();

        // Same value again still restarts the window
        write_window(2);
        send_random(6);
        stop_stream();

        write_window(8);
        send_random(20);
        stop_stream();

        write_window(1);
        calm = 1'b1;
        send_random(30);
        calm = 1'b0;
        stop_stream();

        write_window(27);
        send_random(40);
        stop_stream();

        // Longer window that wraps once
        write_window(64);
        send_random(70);
        stop_stream();

        // Saturated length: the window stays short of full
        write_window(2047);
        send_random(20);
        stop_stream();

        // Hold the output off so the block backs up into its input
        write_window(4);
        hold_cycles = HOLD;
        send_random(30);
        stop_stream();

        // Random lengths, mostly short; some windows never fill
        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            len_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(1, 40);
            count = $urandom_range(20, 60);
            write_window(wamm_pkg::len_t'(len_pick));
            calm = ($urandom_range(0, 3) == 0);
            send_random(count);
            stop_stream();
            random_done += count;
        end
        calm = 1'b0;

        settle(DRAIN);
        $display("Run covered %0d sample beats and %0d checked windows over %0d length writes,",
                 sb.beats, sb.results, phases);
        $display("with zero, repeated, longer and saturating lengths and a long output hold; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
